// File: hw/rtl/psdw_pkg.sv
// Shared types and constants for the PNG stored-deflate writer.
// No dependencies; the front end, queue, back end, writer top and testbench import it.
`timescale 1ns / 1ps
package psdw_pkg;

  // Byte positions in the output script of one item
  localparam logic [6:0] SEG_HDR  = 7'd0;   // signature, IHDR, IDAT head, zlib head
  localparam logic [6:0] IX_IHDR  = 7'd12;  // first byte of the IHDR type
  localparam logic [6:0] IX_IDAT  = 7'd37;  // first byte of the IDAT type
  localparam logic [6:0] SEG_ROW  = 7'd43;  // stored-block header and filter byte
  localparam logic [6:0] SEG_SMP  = 7'd49;  // the sample itself
  localparam logic [6:0] SEG_TAIL = 7'd50;  // Adler, IDAT CRC, IEND chunk
  localparam logic [6:0] IX_IEND  = 7'd62;  // first byte of the IEND type
  localparam logic [6:0] SEG_END  = 7'd69;  // final byte of the file

  localparam logic [31:0] CRC_POLY  = 32'hedb88320;
  localparam logic [31:0] CRC_INIT  = 32'hffffffff;
  localparam logic [16:0] ADLER_MOD = 17'd65521;

  // Config register indexes
  localparam logic [1:0] REG_WIDTH    = 2'd0;
  localparam logic [1:0] REG_HEIGHT   = 2'd1;
  localparam logic [1:0] REG_CHANNELS = 2'd2;
  localparam logic [1:0] REG_UNUSED   = 2'd3;

  // Image phases
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_DATA = 2'd1;
  localparam logic [1:0] PH_TAIL = 2'd2;
  localparam logic [1:0] PH_DONE = 2'd3;

  // Image settings seen by the back end
  typedef struct packed {
    logic [13:0] width;
    logic [14:0] height;
    logic [2:0]  ctype;
    logic [15:0] row_bytes;
  } cfg_t;

  // One classified input item
  typedef struct packed {
    logic       hdr;
    logic       row;
    logic       bfinal;
    logic       smp;
    logic       tail;
    logic [7:0] data;
  } job_t;

  // Reflected CRC-32 over one byte
  function automatic logic [31:0] crc8(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    return c;
  endfunction

endpackage

// File: hw/rtl/psdw_in_if.sv
// Sample input channel: valid/ready handshake with one 8-bit sample.
// Depends on nothing.
`timescale 1ns / 1ps
interface psdw_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_byte;

  modport source (output valid, output pixel_byte, input ready);
  modport sink (input valid, input pixel_byte, output ready);
endinterface

// File: hw/rtl/psdw_out_if.sv
// Byte output channel: valid/ready handshake with file byte and markers.
// Depends on nothing.
`timescale 1ns / 1ps
interface psdw_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;
  logic       end_of_image;

  modport source (output valid, output out_byte, output last_of_run,
                  output end_of_image, input ready);
  modport sink (input valid, input out_byte, input last_of_run,
                input end_of_image, output ready);
endinterface

// File: hw/rtl/psdw_front.sv
// Front end: config registers, image position tracking, item classification.
// Depends on psdw_pkg and psdw_in_if.
`timescale 1ns / 1ps
module psdw_front
  import psdw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  psdw_in_if.sink     in_if,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [14:0] cfg_data,
  input  logic        q_full,
  output logic        q_push,
  output job_t        q_job,
  output cfg_t        cfg
);

  logic [1:0]  phase_r, phase_nxt;
  logic [15:0] col_r, col_nxt;
  logic [14:0] row_r, row_nxt;
  logic [13:0] width_r;
  logic [14:0] height_r;
  logic [2:0]  chan_r;
  logic [15:0] rb_r;

  logic        acc;
  logic        cfg_ok;
  logic [15:0] col_eff, col_inc;
  logic [14:0] row_eff, row_inc;
  logic [13:0] w_new;
  logic [14:0] h_new;
  logic [2:0]  ch_new;
  logic [2:0]  ctype;

  // Accept whenever the queue has room; finished images drop samples
  assign in_if.ready = !q_full;
  assign acc = in_if.valid && in_if.ready;
  assign cfg_ok = cfg_we && (phase_r == PH_IDLE || phase_r == PH_DONE);

  // Clamp register writes to usable values
  assign w_new  = (cfg_data[13:0] == 14'd0) ? 14'd1 : cfg_data[13:0];
  assign h_new  = (cfg_data[14:0] == 15'd0) ? 15'd1 : cfg_data[14:0];
  assign ch_new = (cfg_data[2:0] == 3'd0) ? 3'd1 :
                  (cfg_data[2:0] > 3'd4) ? 3'd4 : cfg_data[2:0];

  // Map channel count to PNG color type
  always_comb begin
    unique case (chan_r)
      3'd1:    ctype = 3'd0;
      3'd2:    ctype = 3'd4;
      3'd3:    ctype = 3'd2;
      default: ctype = 3'd6;
    endcase
  end

  assign cfg.width     = width_r;
  assign cfg.height    = height_r;
  assign cfg.ctype     = ctype;
  assign cfg.row_bytes = rb_r;

  // Classify the item and advance the image position
  always_comb begin
    col_eff = (phase_r == PH_IDLE) ? 16'd0 : col_r;
    row_eff = (phase_r == PH_IDLE) ? 15'd0 : row_r;
    col_inc = col_eff + 16'd1;
    row_inc = row_eff + 15'd1;

    q_job.hdr    = (phase_r == PH_IDLE);
    q_job.row    = (phase_r != PH_TAIL) && (col_eff == 16'd0);
    q_job.bfinal = (row_inc >= height_r);
    q_job.smp    = (phase_r != PH_TAIL);
    q_job.tail   = (phase_r == PH_TAIL);
    q_job.data   = in_if.pixel_byte;

    phase_nxt = phase_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    q_push    = acc && (phase_r != PH_DONE);

    if (acc) begin
      if (phase_r == PH_TAIL) begin
        phase_nxt = PH_DONE;
      end else if (phase_r != PH_DONE) begin
        phase_nxt = PH_DATA;
        col_nxt   = col_inc;
        row_nxt   = row_eff;
        if (col_inc >= rb_r) begin
          col_nxt = 16'd0;
          row_nxt = row_inc;
          if (row_inc >= height_r) begin
            // header and trailer do not fit in one burst: defer the trailer
            if (phase_r == PH_IDLE) begin
              phase_nxt = PH_TAIL;
            end else begin
              q_job.tail = 1'b1;
              phase_nxt  = PH_DONE;
            end
          end
        end
      end
    end

    // A register write while stopped arms a new image
    if (cfg_ok && cfg_index != REG_UNUSED) phase_nxt = PH_IDLE;
  end

  // Hold position and config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      col_r    <= 16'd0;
      row_r    <= 15'd0;
      width_r  <= 14'd1;
      height_r <= 15'd1;
      chan_r   <= 3'd3;
      rb_r     <= 16'd3;
    end else begin
      phase_r <= phase_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      if (cfg_ok) begin
        unique case (cfg_index)
          REG_WIDTH: begin
            width_r <= w_new;
            rb_r    <= 16'(w_new * chan_r);
          end
          REG_HEIGHT: begin
            height_r <= h_new;
          end
          REG_CHANNELS: begin
            chan_r <= ch_new;
            rb_r   <= 16'(width_r * ch_new);
          end
          default: ;
        endcase
      end
    end
  end

endmodule

// File: hw/rtl/psdw_queue.sv
// Two-entry job queue between the front and back ends.
// Depends on psdw_pkg.
`timescale 1ns / 1ps
module psdw_queue
  import psdw_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t wdata,
  input  logic pop,
  output job_t rdata,
  output logic full,
  output logic empty
);

  job_t       mem_r [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign rdata = mem_r[rp_r];

  // Store on push
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wdata;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop) rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) !(pop && empty))
    else $error("queue pop while empty");

endmodule

// File: hw/rtl/psdw_back.sv
// Back end: byte sequencer with chunk CRC, Adler-32 and output register.
// Depends on psdw_pkg and psdw_out_if.
`timescale 1ns / 1ps
module psdw_back
  import psdw_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       q_empty,
  input  job_t       q_head,
  output logic       q_pop,
  psdw_out_if.source out_if
);

  logic [6:0]  idx_r;
  logic        active_r;
  logic [31:0] crc_r;
  logic [15:0] alo_r, ahi_r;
  logic [31:0] idat_r;
  logic        ov_r;
  logic [7:0]  ob_r;
  logic        olast_r, oeoi_r;

  logic [6:0]  cur;
  logic        adv;
  logic        last;
  logic [7:0]  b;
  logic        crc_en, crc_rst, adl_en;
  logic [31:0] ncrc;
  logic [15:0] len, nlen;
  logic [16:0] lo_s, hi_s;
  logic [15:0] lo_n, hi_n;

  // Current script position: resume or start a fresh job
  always_comb begin
    if (active_r) cur = idx_r;
    else if (q_head.hdr) cur = SEG_HDR;
    else if (q_head.row) cur = SEG_ROW;
    else if (q_head.smp) cur = SEG_SMP;
    else cur = SEG_TAIL;
  end

  assign adv   = !q_empty && (!ov_r || out_if.ready);
  assign last  = (cur == SEG_SMP && !q_head.tail) || (cur == SEG_END);
  assign q_pop = adv && last;
  assign len   = cfg.row_bytes + 16'd1;
  assign nlen  = ~len;
  assign ncrc  = ~crc_r;

  // Select the byte and its checksum coverage
  always_comb begin
    b = 8'h00;
    case (cur)
      7'd0:  b = 8'h89;
      7'd1:  b = 8'h50;
      7'd2:  b = 8'h4e;
      7'd3:  b = 8'h47;
      7'd4:  b = 8'h0d;
      7'd5:  b = 8'h0a;
      7'd6:  b = 8'h1a;
      7'd7:  b = 8'h0a;
      7'd11: b = 8'h0d;
      7'd12: b = 8'h49;
      7'd13: b = 8'h48;
      7'd14: b = 8'h44;
      7'd15: b = 8'h52;
      7'd18: b = {2'b00, cfg.width[13:8]};
      7'd19: b = cfg.width[7:0];
      7'd22: b = {1'b0, cfg.height[14:8]};
      7'd23: b = cfg.height[7:0];
      7'd24: b = 8'h08;
      7'd25: b = {5'd0, cfg.ctype};
      7'd29, 7'd54, 7'd66: b = ncrc[31:24];
      7'd30, 7'd55, 7'd67: b = ncrc[23:16];
      7'd31, 7'd56, 7'd68: b = ncrc[15:8];
      7'd32, 7'd57, 7'd69: b = ncrc[7:0];
      7'd33: b = idat_r[31:24];
      7'd34: b = idat_r[23:16];
      7'd35: b = idat_r[15:8];
      7'd36: b = idat_r[7:0];
      7'd37: b = 8'h49;
      7'd38: b = 8'h44;
      7'd39: b = 8'h41;
      7'd40: b = 8'h54;
      7'd41: b = 8'h78;
      7'd42: b = 8'h01;
      7'd43: b = {7'd0, q_head.bfinal};
      7'd44: b = len[7:0];
      7'd45: b = len[15:8];
      7'd46: b = nlen[7:0];
      7'd47: b = nlen[15:8];
      7'd49: b = q_head.data;
      7'd50: b = ahi_r[15:8];
      7'd51: b = ahi_r[7:0];
      7'd52: b = alo_r[15:8];
      7'd53: b = alo_r[7:0];
      7'd62: b = 8'h49;
      7'd63: b = 8'h45;
      7'd64: b = 8'h4e;
      7'd65: b = 8'h44;
      default: b = 8'h00;
    endcase
    crc_en  = (cur >= IX_IHDR && cur <= 7'd28) || (cur >= IX_IDAT && cur <= 7'd53) ||
              (cur >= IX_IEND && cur <= 7'd65);
    crc_rst = (cur == IX_IHDR) || (cur == IX_IDAT) || (cur == IX_IEND);
    adl_en  = (cur == SEG_ROW + 7'd5) || (cur == SEG_SMP);
  end

  // Adler-32 step over the data byte
  always_comb begin
    lo_s = {1'b0, alo_r} + {9'd0, b};
    lo_n = (lo_s >= ADLER_MOD) ? 16'(lo_s - ADLER_MOD) : lo_s[15:0];
    hi_s = {1'b0, ahi_r} + {1'b0, lo_n};
    hi_n = (hi_s >= ADLER_MOD) ? 16'(hi_s - ADLER_MOD) : hi_s[15:0];
  end

  // Precompute IDAT length from the settled config
  always_ff @(posedge clk) begin
    idat_r <= 32'(cfg.height) * 32'({1'b0, cfg.row_bytes} + 17'd6) + 32'd6;
  end

  // Advance the script, checksums and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r    <= SEG_HDR;
      active_r <= 1'b0;
      crc_r    <= CRC_INIT;
      alo_r    <= 16'd1;
      ahi_r    <= 16'd0;
      ov_r     <= 1'b0;
    end else if (adv) begin
      ov_r    <= 1'b1;
      ob_r    <= b;
      olast_r <= last;
      oeoi_r  <= (cur == SEG_END);
      if (cur == SEG_END) crc_r <= CRC_INIT;
      else if (crc_en) crc_r <= crc8(crc_rst ? CRC_INIT : crc_r, b);
      if (cur == SEG_HDR) begin
        alo_r <= 16'd1;
        ahi_r <= 16'd0;
      end else if (adl_en) begin
        alo_r <= lo_n;
        ahi_r <= hi_n;
      end
      if (last) begin
        active_r <= 1'b0;
      end else begin
        idx_r    <= cur + 7'd1;
        active_r <= 1'b1;
      end
    end else if (out_if.ready) begin
      ov_r <= 1'b0;
    end
  end

  assign out_if.valid        = ov_r;
  assign out_if.out_byte     = ob_r;
  assign out_if.last_of_run  = olast_r;
  assign out_if.end_of_image = oeoi_r;

  a_eoi_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
      ov_r && oeoi_r |-> olast_r)
    else $error("end of image without end of run");
  a_active_mid_job: assert property (@(posedge clk) disable iff (!rst_n)
      active_r |-> !q_empty)
    else $error("job in progress with empty queue");

endmodule

// File: hw/rtl/png_stored_deflate_writer.sv
// PNG stored-deflate writer: Each accepted 8-bit sample yields its share of an
// uncompressed PNG file, one byte per cycle on the output channel while the
// receiver is ready: one byte for an ordinary sample, seven at the start of a
// row, fifty for the first sample of an image, and twenty more for the trailer
// after the last sample. Samples are taken one per cycle while the two-entry job
// queue has room; the output byte sequencer, one byte per clock while the
// receiver is ready, sets the throughput. Config writes are taken only before an
// image starts or after it ends; each one to a used register arms a new image.
// Depends on psdw_pkg, psdw_in_if, psdw_out_if, psdw_front, psdw_queue, psdw_back.
`timescale 1ns / 1ps
module png_stored_deflate_writer
  import psdw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  psdw_in_if.sink     in_if,
  psdw_out_if.source  out_if,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [14:0] cfg_data
);

  logic q_push, q_pop, q_full, q_empty;
  job_t q_wjob, q_rjob;
  cfg_t cfg;

  psdw_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (q_wjob),
    .cfg       (cfg)
  );

  psdw_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wjob),
    .pop   (q_pop),
    .rdata (q_rjob),
    .full  (q_full),
    .empty (q_empty)
  );

  psdw_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .q_empty (q_empty),
    .q_head  (q_rjob),
    .q_pop   (q_pop),
    .out_if  (out_if)
  );

endmodule

// File: tb/sv/tb_top.sv
// Self-checking testbench for png_stored_deflate_writer: streams pixel samples
// through images of many shapes and checks every file byte against a predictor.
// Depends on psdw_pkg, psdw_in_if, psdw_out_if and the writer RTL.
`timescale 1ns / 1ps
module tb_top
  import psdw_pkg::*;
();

  localparam logic [31:0] ADLER_BASE = 32'd65521;
  localparam int          MAX_RUN    = 50;

  typedef struct {
    logic [7:0] data;
    logic       last;
    logic       eoi;
  } file_byte_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [14:0] cfg_data;

  psdw_in_if  in_ch ();
  psdw_out_if out_ch ();

  png_stored_deflate_writer i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Clock: 4 ns period
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Predictor state
  logic [13:0] img_width;
  logic [14:0] img_height;
  logic [2:0]  img_channels;
  logic [31:0] crc_reg;
  logic [31:0] adler_lo;
  logic [31:0] adler_hi;
  logic [31:0] col_cnt;
  logic [31:0] row_cnt;
  logic [1:0]  phase;

  file_byte_t  run_bytes[$];
  file_byte_t  file_bytes_due[$];
  logic [7:0]  samples_pending[$];
  bit          failed;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 96) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic emit(input logic [31:0] v, input bit with_crc);
    file_byte_t fb;
    logic [31:0] c;
    if (with_crc) begin
      c = crc_reg ^ {24'd0, v[7:0]};
      for (int i = 0; i < 8; i++) begin
        c = c[0] ? ((c >> 1) ^ 32'hedb88320) : (c >> 1);
      end
      crc_reg = c;
    end
    fb.data = v[7:0];
    fb.last = 1'b0;
    fb.eoi  = 1'b0;
    run_bytes = {run_bytes, fb};
  endtask

  task automatic emit_be32(input logic [31:0] v, input bit with_crc);
    for (int i = 3; i >= 0; i--) emit(v >> (8 * i), with_crc);
  endtask

  task automatic emit_chunk_type(input logic [31:0] tag);
    crc_reg = 32'hffffffff;
    emit_be32(tag, 1'b1);
  endtask

  task automatic emit_zlib_data(input logic [7:0] b);
    emit({24'd0, b}, 1'b1);
    adler_lo = adler_lo + {24'd0, b};
    if (adler_lo >= ADLER_BASE) adler_lo = adler_lo - ADLER_BASE;
    adler_hi = adler_hi + adler_lo;
    if (adler_hi >= ADLER_BASE) adler_hi = adler_hi - ADLER_BASE;
  endtask

  task automatic emit_trailer();
    emit_be32((adler_hi << 16) | adler_lo, 1'b1);
    emit_be32(~crc_reg, 1'b0);
    emit_be32(32'd0, 1'b0);
    emit_chunk_type("IEND");
    emit_be32(~crc_reg, 1'b0);
    run_bytes[run_bytes.size() - 1].eoi = 1'b1;
    crc_reg = 32'hffffffff;
    phase   = PH_DONE;
  endtask

  task automatic predict_config(input logic [1:0] idx, input logic [14:0] value);
    if (phase == PH_DATA || phase == PH_TAIL) return;
    case (idx)
      REG_WIDTH:    img_width    = value[13:0];
      REG_HEIGHT:   img_height   = value[14:0];
      REG_CHANNELS: img_channels = value[2:0];
      default: return;
    endcase
    phase = PH_IDLE;
  endtask

  // Work out the file bytes that one accepted sample brings out
  task automatic predict_sample(input logic [7:0] px);
    logic [31:0] w, h, ch, rb, len;
    logic [7:0]  ctype;
    w  = (img_width == 0) ? 32'd1 : 32'(img_width);
    h  = (img_height == 0) ? 32'd1 : 32'(img_height);
    ch = (img_channels == 0) ? 32'd1 : (img_channels > 4) ? 32'd4 : 32'(img_channels);
    rb = w * ch;
    run_bytes.delete();
    if (phase == PH_DONE) return;
    if (phase == PH_TAIL) begin
      emit_trailer();
    end else begin
      if (phase == PH_IDLE) begin
        case (ch)
          1: ctype = 8'd0;
          2: ctype = 8'd4;
          3: ctype = 8'd2;
          default: ctype = 8'd6;
        endcase
        emit_be32(32'h89504e47, 1'b0);
        emit_be32(32'h0d0a1a0a, 1'b0);
        emit_be32(32'd13, 1'b0);
        emit_chunk_type("IHDR");
        emit_be32(w, 1'b1);
        emit_be32(h, 1'b1);
        emit(32'd8, 1'b1);
        emit({24'd0, ctype}, 1'b1);
        emit(32'd0, 1'b1);
        emit(32'd0, 1'b1);
        emit(32'd0, 1'b1);
        emit_be32(~crc_reg, 1'b0);
        emit_be32(32'd2 + h * (rb + 32'd6) + 32'd4, 1'b0);
        emit_chunk_type("IDAT");
        emit(32'h78, 1'b1);
        emit(32'h01, 1'b1);
        adler_lo = 1;
        adler_hi = 0;
        col_cnt  = 0;
        row_cnt  = 0;
        phase    = PH_DATA;
      end
      // Stored-block header and filter byte at the start of each row
      if (col_cnt == 0) begin
        len = rb + 1;
        emit((row_cnt + 1 >= h) ? 32'd1 : 32'd0, 1'b1);
        emit(len, 1'b1);
        emit(len >> 8, 1'b1);
        emit(~len, 1'b1);
        emit((~len) >> 8, 1'b1);
        emit_zlib_data(8'd0);
      end
      emit_zlib_data(px);
      col_cnt++;
      if (col_cnt >= rb) begin
        col_cnt = 0;
        row_cnt++;
        if (row_cnt >= h) begin
          if (run_bytes.size() + 20 > MAX_RUN) phase = PH_TAIL;
          else emit_trailer();
        end
      end
    end
    if (run_bytes.size() > 0) run_bytes[run_bytes.size() - 1].last = 1'b1;
    file_bytes_due = {file_bytes_due, run_bytes};
  endtask

  // Sample driver: track register writes, offer pending samples with random gaps,
  // predict on transaction
  int send_gap;
  always @(posedge clk) begin
    logic       nxt_valid;
    logic [7:0] nxt_byte;
    nxt_valid = in_ch.valid;
    nxt_byte  = in_ch.pixel_byte;
    if (!rst_n) begin
      nxt_valid    = 1'b0;
      nxt_byte     = 8'd0;
      send_gap     = 0;
      img_width    = 14'd1;
      img_height   = 15'd1;
      img_channels = 3'd3;
      crc_reg      = 32'hffffffff;
      adler_lo     = 1;
      adler_hi     = 0;
      col_cnt      = 0;
      row_cnt      = 0;
      phase        = PH_IDLE;
    end else begin
      if (cfg_we) predict_config(cfg_index, cfg_data);
      if (in_ch.valid && in_ch.ready) begin
        predict_sample(in_ch.pixel_byte);
        nxt_valid = 1'b0;
      end
      if (!(in_ch.valid && !in_ch.ready)) begin
        if (send_gap > 0) begin
          send_gap--;
          nxt_valid = 1'b0;
        end else if (samples_pending.size() > 0) begin
          nxt_byte  = samples_pending.pop_front();
          nxt_valid = 1'b1;
          send_gap  = gap_len();
        end
      end
    end
    in_ch.valid      <= nxt_valid;
    in_ch.pixel_byte <= nxt_byte;
  end

  // Byte monitor: random back-pressure, one long hold, compare each transaction
  int  recv_gap;
  bit  long_hold_done;
  always @(posedge clk) begin
    file_byte_t fb;
    logic       nxt_ready;
    if (!rst_n) begin
      recv_gap       = 0;
      long_hold_done = 1'b0;
      failed         = 1'b0;
      nxt_ready      = 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (file_bytes_due.size() == 0) begin
          $display("%0t: unexpected byte %02h last=%b eoi=%b", $time,
                   out_ch.out_byte, out_ch.last_of_run, out_ch.end_of_image);
          failed = 1'b1;
        end else begin
          fb = file_bytes_due.pop_front();
          if (fb.data !== out_ch.out_byte || fb.last !== out_ch.last_of_run ||
              fb.eoi !== out_ch.end_of_image) begin
            $display("%0t: expected %02h last=%b eoi=%b, got %02h last=%b eoi=%b",
                     $time, fb.data, fb.last, fb.eoi, out_ch.out_byte,
                     out_ch.last_of_run, out_ch.end_of_image);
            failed = 1'b1;
          end
        end
      end
      // Hold off for a long stretch once, while the sender still has plenty queued
      if (!long_hold_done && samples_pending.size() > 100) begin
        long_hold_done = 1'b1;
        recv_gap       = 600;
      end
      if (recv_gap > 0) begin
        recv_gap--;
        nxt_ready = 1'b0;
      end else begin
        nxt_ready = 1'b1;
        recv_gap  = gap_len();
      end
    end
    out_ch.ready <= nxt_ready;
  end

  // Wait until the block has drained, then write width, height and channels, and the unused register if asked
  task automatic configure(input logic [14:0] w, input logic [14:0] h,
                           input logic [14:0] ch, input bit poke_unused);
    while (samples_pending.size() > 0 || in_ch.valid || file_bytes_due.size() > 0)
      @(posedge clk);
    repeat (80) @(posedge clk);
    for (int i = 0; i < 4; i++) begin
      logic [1:0]  idx;
      logic [14:0] val;
      idx = 2'(i);
      val = (idx == REG_WIDTH) ? w : (idx == REG_HEIGHT) ? h :
            (idx == REG_CHANNELS) ? ch : 15'($urandom);
      if (idx != REG_UNUSED || poke_unused) begin
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
      end
    end
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Queue one image worth of samples plus a few that follow it
  task automatic send_image(input int mode);
    int w, h, ch, total, extra;
    logic [7:0] px;
    w  = (img_width == 0) ? 1 : int'(img_width);
    h  = (img_height == 0) ? 1 : int'(img_height);
    ch = (img_channels == 0) ? 1 : (img_channels > 4) ? 4 : int'(img_channels);
    total = w * h * ch;
    extra = $urandom_range(0, 2) + ((total == 1) ? 1 : 0);
    for (int i = 0; i < total + extra; i++) begin
      case (mode)
        1: px = 8'hff;
        2: px = (i % 2) ? 8'hff : 8'h00;
        default: px = ($urandom_range(0, 3) == 0) ? 8'hff : 8'($urandom);
      endcase
      samples_pending = {samples_pending, px};
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = REG_WIDTH;
    cfg_data  = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: settings left at reset, then zero and oversized registers
    send_image(2);
    configure(15'd1, 15'd1, 15'd1, 1'b1);
    send_image(1);
    configure(15'd0, 15'd0, 15'd0, 1'b0);
    send_image(2);
    configure(15'd2, 15'd2, 15'd5, 1'b1);
    send_image(1);
    // Width bit above the register is dropped; writes mid-image are ignored
    configure(15'h4005, 15'd1, 15'd2, 1'b0);
    samples_pending = {samples_pending, 8'h00};
    configure(15'd3, 15'd1, 15'd7, 1'b0);
    send_image(2);

    // Row long enough that the stored length uses its high byte
    configure(15'd64, 15'd1, 15'd4, 1'b0);
    send_image(0);

    // Random images, mostly small
    for (int n = 0; n < 5; n++) begin
      configure(15'($urandom_range(0, 6)), 15'($urandom_range(0, 3)),
                15'($urandom_range(0, 7)), $urandom_range(0, 3) == 0);
      send_image(0);
    end

    while (samples_pending.size() > 0 || in_ch.valid || file_bytes_due.size() > 0)
      @(posedge clk);
    repeat (100) @(posedge clk);
    if (!failed) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20ms;
    $display("Verification failed");
    $finish;
  end

endmodule
